// ===== hdl/itda_pkg.sv =====
package itda_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_SIGN,
		ST_DIGITS
	} back_state_t;

endpackage

// ===== hdl/itda_front.sv =====
module itda_front #(
	parameter int WIDTH = 32
) (
	input  logic             start,
	input  logic             full,
	input  logic [WIDTH-1:0] value,
	input  logic             signed_mode,
	output logic             busy,
	output logic             push,
	output logic [WIDTH:0]   push_data
);

	logic             neg;
	logic [WIDTH-1:0] mag;

	always_comb begin
		neg = signed_mode & value[WIDTH-1];
		mag = neg ? (~value + WIDTH'(1)) : value;
	end

	assign busy      = full;
	assign push      = start & ~full;
	assign push_data = {neg, mag};

endmodule

// ===== hdl/itda_fifo.sv =====
module itda_fifo #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] entries_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/itda_back.sv =====
module itda_back #(
	parameter int WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  logic [WIDTH:0] head,
	output logic           pop,
	output logic           strobe,
	output logic [7:0]     char_code,
	output logic           last
);

	localparam int NDIG = (WIDTH * 30103) / 100000 + 1;
	localparam int IDXW = $clog2(NDIG);
	localparam int CNTW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	itda_pkg::back_state_t state_q, state_d;

	logic [WIDTH-1:0]  shift_q;
	logic [4*NDIG-1:0] bcd_q;
	logic [4*NDIG-1:0] bcd_adj;
	logic [CNTW-1:0]   cnt_q;
	logic [IDXW-1:0]   idx_q;
	logic [IDXW-1:0]   top;
	logic              neg_q;
	logic [3:0]        digit;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		top = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top = IDXW'(i);
			end
		end
	end

	assign digit = bcd_q[4*idx_q +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		strobe    = 1'b0;
		char_code = itda_pkg::CH_ZERO;
		last      = 1'b0;
		unique case (state_q)
			itda_pkg::ST_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = itda_pkg::ST_CONV;
				end
			end
			itda_pkg::ST_CONV: begin
				if (cnt_q == CNTW'(WIDTH - 1)) begin
					state_d = itda_pkg::ST_SCAN;
				end
			end
			itda_pkg::ST_SCAN: begin
				state_d = neg_q ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGITS;
			end
			itda_pkg::ST_SIGN: begin
				strobe    = 1'b1;
				char_code = itda_pkg::CH_MINUS;
				state_d   = itda_pkg::ST_DIGITS;
			end
			itda_pkg::ST_DIGITS: begin
				strobe    = 1'b1;
				char_code = itda_pkg::CH_ZERO + {4'b0, digit};
				last      = (idx_q == '0);
				if (idx_q == '0) begin
					state_d = itda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itda_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			itda_pkg::ST_IDLE: begin
				shift_q <= head[WIDTH-1:0];
				neg_q   <= head[WIDTH];
				bcd_q   <= '0;
				cnt_q   <= '0;
			end
			itda_pkg::ST_CONV: begin
				bcd_q   <= {bcd_adj[4*NDIG-2:0], shift_q[WIDTH-1]};
				shift_q <= shift_q << 1;
				cnt_q   <= cnt_q + CNTW'(1);
			end
			itda_pkg::ST_SCAN: begin
				idx_q <= top;
			end
			itda_pkg::ST_DIGITS: begin
				idx_q <= idx_q - IDXW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/int_to_decimal_ascii.sv =====
// Channel   Ports                          Handshake
// request   value, signed_mode             start high, busy low at clk edge
// result    char_code, last                strobe high for one cycle
//
// Each request goes through shift-and-add-3 conversion in the back unit,
// then a leading-zero scan, then one character per cycle (up to 11 at
// WIDTH 32).
// A two-entry queue holds requests while the back unit works; busy is high
// when it is full. Reset clears the queue and the back state machine.
// Results cannot be stalled by the receiver.
module int_to_decimal_ascii #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] value,
	input  logic             signed_mode,
	output logic             strobe,
	output logic [7:0]       char_code,
	output logic             last
);

	logic           push;
	logic [WIDTH:0] push_data;
	logic           pop;
	logic [WIDTH:0] head;
	logic           full;
	logic           empty;

	itda_front #(.WIDTH(WIDTH)) u_front (
		.start       (start),
		.full        (full),
		.value       (value),
		.signed_mode (signed_mode),
		.busy        (busy),
		.push        (push),
		.push_data   (push_data)
	);

	itda_fifo #(.W(WIDTH + 1)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	itda_back #(.WIDTH(WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last)
	);

endmodule
